// File: rtl/alcd_pkg.sv
// ----------------------------------------------------------------------------
// alcd_pkg
// Shared types and constants of the approximate LRU block cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package alcd_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int BLOCK_BITS = 48;
  localparam int STAMP_W    = 64;
  localparam int REFS_W     = 8;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int SHIFT_W    = 3;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SCAN_W     = 7;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;
  localparam logic [REFS_W-1:0]  REFS_MAX    = 8'd255;
  localparam logic [REFS_W-1:0]  REFS_NEW    = 8'd2;
  localparam logic [REFS_W-1:0]  REFS_KEEP   = 8'd1;

  localparam logic [FUNC_W-1:0] FN_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INVAL = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SHRNK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADSLOT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFOVF  = 2'd3;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] block;
    logic [STAMP_W-1:0]    stamp;
    logic [REFS_W-1:0]     refs;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/alcd_in_if.sv
// ----------------------------------------------------------------------------
// alcd_in_if
// Request channel: valid/ready handshake with operation payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface alcd_in_if;
  logic                             valid;
  logic                             ready;
  logic [alcd_pkg::FUNC_W-1:0]      func;
  logic [alcd_pkg::BLOCK_BITS-1:0]  block_number;
  logic [alcd_pkg::SLOT_W-1:0]      slot_select;
  logic [alcd_pkg::SCAN_W-1:0]      scan_count;

  modport source (output valid, func, block_number, slot_select, scan_count,
                  input ready);
  modport sink   (input valid, func, block_number, slot_select, scan_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/alcd_out_if.sv
// ----------------------------------------------------------------------------
// alcd_out_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface alcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [alcd_pkg::STATUS_W-1:0]  status;
  logic                           hit;
  logic [alcd_pkg::SLOT_W-1:0]    slot_index;
  logic [alcd_pkg::REFS_W-1:0]    references;
  logic [alcd_pkg::SCAN_W-1:0]    removed;
  logic [alcd_pkg::CNT_W-1:0]     population;

  modport source (output valid, status, hit, slot_index, references, removed,
                  population, input ready);
  modport sink   (input valid, status, hit, slot_index, references, removed,
                  population, output ready);
endinterface

`default_nettype wire

// File: rtl/approx_lru_block_cache_directory.sv
// Timing: get walks the slots in order, one slot memory read per slot, until a hit
// or the last slot; put and invalidate read only the selected slot (an unallocated
// slot goes straight to the result); shrink walks all slots per removed entry, plus
// a final walk that finds no candidate when too few entries qualify.
// One request in flight; the next is taken in the cycle after the result loads.
// Reset: all slots free, population and move counter zero, recent_shift 3.
// ----------------------------------------------------------------------------
// approx_lru_block_cache_directory
// Slot directory with reference counts and approximate LRU stamp ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module approx_lru_block_cache_directory (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [alcd_pkg::SHIFT_W-1:0]  cfg_wdata,
  alcd_in_if.sink                            in_if,
  alcd_out_if.source                         out_if
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HIT  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_SHR  = 3'd5;
  localparam logic [2:0] S_SREM = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [alcd_pkg::SLOT_W-1:0] LAST_SLOT =
    alcd_pkg::SLOT_W'(alcd_pkg::SLOTS - 1);

  alcd_pkg::entry_t mem [alcd_pkg::SLOTS];
  alcd_pkg::entry_t rd_q_r;
  alcd_pkg::entry_t wr_data;
  logic                              wr_en;
  logic [alcd_pkg::SLOT_W-1:0]       wr_addr;

  logic [2:0] st_r, st_nxt;
  logic [alcd_pkg::SLOTS-1:0] alloc_r, alloc_nxt, cached_r, cached_nxt;
  logic [alcd_pkg::STAMP_W-1:0] mc_r, mc_nxt;
  logic [alcd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [alcd_pkg::SHIFT_W-1:0] shift_r;
  logic [alcd_pkg::SLOT_W-1:0] ptr_r, ptr_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [alcd_pkg::SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic any_r, any_nxt;
  logic [alcd_pkg::SLOT_W-1:0] best_r, best_nxt;
  logic [alcd_pkg::STAMP_W-1:0] best_stamp_r, best_stamp_nxt;

  logic [alcd_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [alcd_pkg::BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [alcd_pkg::SLOT_W-1:0] sel_r, sel_nxt;
  logic [alcd_pkg::SCAN_W-1:0] nr_r, nr_nxt;

  logic [alcd_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic res_hit_r, res_hit_nxt;
  logic [alcd_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [alcd_pkg::REFS_W-1:0] res_refs_r, res_refs_nxt;
  logic [alcd_pkg::SCAN_W-1:0] res_rem_r, res_rem_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [alcd_pkg::STATUS_W-1:0] o_status_r;
  logic o_hit_r;
  logic [alcd_pkg::SLOT_W-1:0] o_slot_r;
  logic [alcd_pkg::REFS_W-1:0] o_refs_r;
  logic [alcd_pkg::SCAN_W-1:0] o_rem_r;
  logic [alcd_pkg::CNT_W-1:0] o_pop_r;
  logic o_load;

  logic in_xfer;
  logic [alcd_pkg::CNT_W-1:0] recent, recent_new, cnt_inc;
  logic [alcd_pkg::STAMP_W-1:0] mc_inc, mc_lim;
  logic [alcd_pkg::REFS_W-1:0] refs_dec;
  logic cand;

  assign in_xfer      = in_if.valid && in_if.ready;
  assign in_if.ready  = (st_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = o_status_r;
  assign out_if.hit        = o_hit_r;
  assign out_if.slot_index = o_slot_r;
  assign out_if.references = o_refs_r;
  assign out_if.removed    = o_rem_r;
  assign out_if.population = o_pop_r;

  assign recent     = cnt_r >> shift_r;
  assign cnt_inc    = cnt_r + alcd_pkg::CNT_W'(1);
  assign recent_new = cnt_inc >> shift_r;
  assign mc_inc     = mc_r + alcd_pkg::STAMP_W'(1);
  assign mc_lim     = mc_r - alcd_pkg::STAMP_W'(recent);
  assign refs_dec   = (rd_q_r.refs == '0) ? '0 : rd_q_r.refs - alcd_pkg::REFS_W'(1);
  assign cand       = cached_r[ptr_r] && (rd_q_r.refs <= alcd_pkg::REFS_KEEP) &&
                      (!any_r || (rd_q_r.stamp < best_stamp_r));

  always_comb begin
    st_nxt = st_r;
    alloc_nxt = alloc_r;
    cached_nxt = cached_r;
    mc_nxt = mc_r;
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    free_ok_nxt = free_ok_r;
    free_idx_nxt = free_idx_r;
    any_nxt = any_r;
    best_nxt = best_r;
    best_stamp_nxt = best_stamp_r;
    func_nxt = func_r;
    blk_nxt = blk_r;
    sel_nxt = sel_r;
    nr_nxt = nr_r;
    res_status_nxt = res_status_r;
    res_hit_nxt = res_hit_r;
    res_slot_nxt = res_slot_r;
    res_refs_nxt = res_refs_r;
    res_rem_nxt = res_rem_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    o_load = 1'b0;
    wr_en = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_q_r;

    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt = in_if.func;
          blk_nxt = in_if.block_number;
          sel_nxt = in_if.slot_select;
          nr_nxt = in_if.scan_count;
          res_status_nxt = alcd_pkg::ST_OK;
          res_hit_nxt = 1'b0;
          res_slot_nxt = '0;
          res_refs_nxt = '0;
          res_rem_nxt = '0;
          free_ok_nxt = 1'b0;
          any_nxt = 1'b0;
          ptr_nxt = '0;
          case (in_if.func)
            alcd_pkg::FN_GET: st_nxt = S_SCAN;
            alcd_pkg::FN_PUT, alcd_pkg::FN_INVAL: begin
              ptr_nxt = in_if.slot_select;
              if (!alloc_r[in_if.slot_select]) begin
                res_status_nxt = alcd_pkg::ST_BADSLOT;
                st_nxt = S_DONE;
              end else begin
                st_nxt = S_RD;
              end
            end
            default: st_nxt = (in_if.scan_count == '0) ? S_DONE : S_SHR;
          endcase
        end
      end
      S_SCAN: begin
        if (!alloc_r[ptr_r] && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_idx_nxt = ptr_r;
        end
        if (cached_r[ptr_r] && (rd_q_r.block == blk_r)) begin
          st_nxt = S_HIT;
        end else if (ptr_r == LAST_SLOT) begin
          st_nxt = S_MISS;
        end else begin
          ptr_nxt = ptr_r + alcd_pkg::SLOT_W'(1);
        end
      end
      S_HIT: begin
        res_hit_nxt = 1'b1;
        res_slot_nxt = ptr_r;
        if (rd_q_r.refs == alcd_pkg::REFS_MAX) begin
          res_status_nxt = alcd_pkg::ST_REFOVF;
          res_refs_nxt = rd_q_r.refs;
        end else begin
          wr_en = 1'b1;
          wr_data.refs = rd_q_r.refs + alcd_pkg::REFS_W'(1);
          res_refs_nxt = wr_data.refs;
          if (rd_q_r.stamp < mc_lim) begin
            mc_nxt = mc_inc;
            wr_data.stamp = mc_inc;
          end
        end
        st_nxt = S_DONE;
      end
      S_MISS: begin
        if (!free_ok_r) begin
          res_status_nxt = alcd_pkg::ST_FULL;
        end else begin
          wr_en = 1'b1;
          wr_addr = free_idx_r;
          wr_data.block = blk_r;
          wr_data.refs = alcd_pkg::REFS_NEW;
          // touch after insert moves again only when the window wraps
          if (alcd_pkg::STAMP_W'(recent_new) > mc_inc) begin
            wr_data.stamp = mc_inc + alcd_pkg::STAMP_W'(1);
          end else begin
            wr_data.stamp = mc_inc;
          end
          mc_nxt = wr_data.stamp;
          cnt_nxt = cnt_inc;
          alloc_nxt[free_idx_r] = 1'b1;
          cached_nxt[free_idx_r] = 1'b1;
          res_slot_nxt = free_idx_r;
          res_refs_nxt = alcd_pkg::REFS_NEW;
        end
        st_nxt = S_DONE;
      end
      S_RD: begin
        if (func_r == alcd_pkg::FN_PUT || cached_r[ptr_r]) begin
          if (cached_r[ptr_r] && cnt_r != '0) begin
            cnt_nxt = cnt_r - alcd_pkg::CNT_W'(1);
          end
          if (func_r == alcd_pkg::FN_INVAL) begin
            res_rem_nxt = alcd_pkg::SCAN_W'(1);
            cached_nxt[ptr_r] = 1'b0;
          end
          if (refs_dec == '0) begin
            alloc_nxt[ptr_r] = 1'b0;
            cached_nxt[ptr_r] = 1'b0;
          end else begin
            if (func_r == alcd_pkg::FN_PUT && cached_r[ptr_r]) begin
              cnt_nxt = cnt_r;
            end
            wr_en = 1'b1;
            wr_data.refs = refs_dec;
            res_refs_nxt = refs_dec;
          end
        end else begin
          res_refs_nxt = rd_q_r.refs;
        end
        st_nxt = S_DONE;
      end
      S_SHR: begin
        if (cand) begin
          any_nxt = 1'b1;
          best_nxt = ptr_r;
          best_stamp_nxt = rd_q_r.stamp;
        end
        if (ptr_r == LAST_SLOT) begin
          st_nxt = S_SREM;
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + alcd_pkg::SLOT_W'(1);
        end
      end
      S_SREM: begin
        if (!any_r) begin
          st_nxt = S_DONE;
        end else begin
          alloc_nxt[best_r] = 1'b0;
          cached_nxt[best_r] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - alcd_pkg::CNT_W'(1);
          end
          res_rem_nxt = res_rem_r + alcd_pkg::SCAN_W'(1);
          any_nxt = 1'b0;
          st_nxt = (res_rem_nxt == nr_r) ? S_DONE : S_SHR;
        end
      end
      default: begin
        if (!out_valid_r || out_if.ready) begin
          o_load = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      alloc_r <= '0;
      cached_r <= '0;
      mc_r <= '0;
      cnt_r <= '0;
      shift_r <= alcd_pkg::SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      alloc_r <= alloc_nxt;
      cached_r <= cached_nxt;
      mc_r <= mc_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    free_ok_r <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    any_r <= any_nxt;
    best_r <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    func_r <= func_nxt;
    blk_r <= blk_nxt;
    sel_r <= sel_nxt;
    nr_r <= nr_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r <= res_hit_nxt;
    res_slot_r <= res_slot_nxt;
    res_refs_r <= res_refs_nxt;
    res_rem_r <= res_rem_nxt;
    if (o_load) begin
      o_status_r <= res_status_r;
      o_hit_r <= res_hit_r;
      o_slot_r <= (func_r == alcd_pkg::FN_GET) ? res_slot_r : sel_r & '0;
      o_refs_r <= res_refs_r;
      o_rem_r <= res_rem_r;
      o_pop_r <= cnt_r;
    end
  end

endmodule

`default_nettype wire
